@@ rtl/core/tlbp_pkg.sv @@
// Shared types, codes and a helper function for the two-level branch predictor.
package tlbp_pkg;

  localparam int PcW = 32;
  localparam int MaxBtbEntries = 32;
  localparam int MaxHistory    = 8;

  // Counter value that the tables hold after reset.
  localparam logic [1:0] CNT_INIT_RESET = 2'd1;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_BTB_SIZE  = 3'd0,
    REG_HIST_LEN  = 3'd1,
    REG_TAG_LEN   = 3'd2,
    REG_INIT      = 3'd3,
    REG_GLOB_HIST = 3'd4,
    REG_GLOB_TAB  = 3'd5,
    REG_SHARE     = 3'd6,
    REG_NONE      = 3'd7
  } reg_idx_t;

  localparam logic [1:0] SHARE_PC2  = 2'd1;
  localparam logic [1:0] SHARE_PC16 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FILL,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        command;
    logic [31:0] pc;
    logic [31:0] target_pc;
    logic        taken;
    logic [31:0] predicted_dest;
  } in_item_t;

  typedef struct packed {
    logic        pred_taken;
    logic [31:0] pred_dest;
    logic [31:0] branch_count;
    logic [31:0] flush_count;
  } out_item_t;

  // Two-bit saturating counter step.
  function automatic logic [1:0] sat_step(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up && c != 2'd3) r = c + 2'd1;
    if (!up && c != 2'd0) r = c - 2'd1;
    return r;
  endfunction

endpackage

@@ rtl/core/tlbp_ram.sv @@
// Generic single-port RAM with registered read.
module tlbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

@@ rtl/core/two_level_branch_predictor_btb_unit.sv @@
// Two-level adaptive branch predictor with BTB: top level.
// A predict passes through the read, evaluate and output states, an update through read,
// evaluate, write and output, with a local-table fill when a miss allocates an entry.
// The unit takes one item at a time and stalls its input until the sequencer, with the
// read, evaluate and write steps on single-port RAMs, is back in idle.
// Synchronous active-low reset clears state; a clear pass then rewrites the counters.
module two_level_branch_predictor_btb_unit
  import tlbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int SlotW = (MaxBtbEntries > 1) ? $clog2(MaxBtbEntries) : 1;
  localparam int TabN  = 1 << MaxHistory;
  localparam int CntN  = MaxBtbEntries * TabN;
  localparam int CntW  = $clog2(CntN) > 0 ? $clog2(CntN) : 1;

  // Configuration registers.
  logic [2:0] size_r;
  logic [3:0] hlen_r;
  logic [4:0] tlen_r;
  logic [1:0] init_r;
  logic       ghist_r, gtab_r;
  logic [1:0] share_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0; hlen_r <= 4'd1; tlen_r <= '0; init_r <= CNT_INIT_RESET;
      ghist_r <= 1'b0; gtab_r <= 1'b0; share_r <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BTB_SIZE:  size_r  <= cfg_data[2:0];
        REG_HIST_LEN:  hlen_r  <= cfg_data[3:0];
        REG_TAG_LEN:   tlen_r  <= cfg_data[4:0];
        REG_INIT:      init_r  <= cfg_data[1:0];
        REG_GLOB_HIST: ghist_r <= cfg_data[0];
        REG_GLOB_TAB:  gtab_r  <= cfg_data[0];
        REG_SHARE:     share_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Effective settings.
  logic [2:0] size_e;
  logic [3:0] hlen_e;
  logic [4:0] tlen_e;
  logic [7:0] hmask;
  logic [31:0] tmask;
  always_comb begin
    size_e = (size_r > 3'd5) ? 3'd5 : size_r;
    hlen_e = (hlen_r == 4'd0) ? 4'd1 : ((hlen_r > 4'd8) ? 4'd8 : hlen_r);
    tlen_e = (tlen_r > 5'd30) ? 5'd30 : tlen_r;
    hmask  = 8'((9'd1 << hlen_e) - 9'd1);
    tmask  = (32'd1 << tlen_e) - 32'd1;
  end

  // Item registers and state.
  state_t     state_r, state_nxt;
  in_item_t   item_r;
  logic [SlotW-1:0] slot_r;
  logic [29:0] tag_r;
  logic        hit_r, pred_r;
  logic [7:0]  hist_r;
  logic [7:0]  cidx_r;
  logic [1:0]  cnt_r;
  logic [8:0]  fill_r;
  logic [CntW-1:0] clr_r;
  logic        clr_busy_r;
  logic [31:0] br_r, fl_r;
  out_item_t   out_r;
  logic        ovalid_r;

  // Per-entry small state in flops (read at one slot a cycle).
  logic [MaxBtbEntries-1:0] ev_r;
  logic [29:0] etag_r [MaxBtbEntries];
  logic [7:0]  lhist_r [MaxBtbEntries];
  logic [7:0]  ghist_val_r;

  // Counter RAM: local tables, and the shared table overlaid in a spare region
  // is avoided by keeping it in a RAM of its own.
  logic            lc_we;
  logic [CntW-1:0] lc_addr;
  logic [1:0]      lc_wd, lc_rd;
  logic            gc_we;
  logic [MaxHistory-1:0] gc_addr;
  logic [1:0]      gc_wd, gc_rd;
  logic [31:0]     tg_rd;
  logic            tg_we;

  tlbp_ram #(.Width(2), .Depth(CntN)) u_lcnt (
    .clk, .we(lc_we), .addr(lc_addr), .wdata(lc_wd), .rdata(lc_rd));
  tlbp_ram #(.Width(2), .Depth(TabN)) u_gcnt (
    .clk, .we(gc_we), .addr(gc_addr), .wdata(gc_wd), .rdata(gc_rd));
  tlbp_ram #(.Width(32), .Depth(MaxBtbEntries)) u_tgt (
    .clk, .we(tg_we), .addr(slot_r), .wdata(item_r.target_pc), .rdata(tg_rd));

  // Index computations for an arriving item.
  logic [SlotW-1:0] slot_c;
  logic [29:0] tag_c;
  logic        hit_c;
  logic [7:0]  hist_c, cidx_c;
  always_comb begin
    slot_c = SlotW'((in_data.pc >> 2) & ((32'd1 << size_e) - 32'd1));
    tag_c  = 30'((in_data.pc >> (6'd2 + 6'(size_e))) & tmask);
    hit_c  = ev_r[slot_c] && (etag_r[slot_c] == tag_c);
    // A miss restarts a local history from zero; the prediction is not taken anyway.
    hist_c = ghist_r ? ghist_val_r : (hit_c ? lhist_r[slot_c] : 8'd0);
    cidx_c = hist_c & hmask;
    if (gtab_r && share_r == SHARE_PC2)  cidx_c = cidx_c ^ (in_data.pc[9:2] & hmask);
    if (gtab_r && share_r == SHARE_PC16) cidx_c = cidx_c ^ (in_data.pc[23:16] & hmask);
  end

  logic taking;
  assign taking  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || clr_busy_r;

  logic [1:0] cnt_now;
  assign cnt_now = gtab_r ? gc_rd : lc_rd;

  logic miss_u;
  assign miss_u = !hit_r;
  logic need_fill;
  assign need_fill = item_r.command && miss_u && !gtab_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (taking) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = !item_r.command ? ST_OUT : (need_fill ? ST_FILL : ST_WRITE);
      ST_FILL:  if (fill_r == 9'(TabN - 1)) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_OUT;
      ST_OUT:   if (!ovalid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // RAM controls.
  logic [1:0] cnt_src;
  logic [1:0] new_cnt;
  assign cnt_src = (item_r.command && miss_u && !gtab_r) ? init_r : cnt_r;
  assign new_cnt = sat_step(cnt_src, item_r.taken);

  always_comb begin
    lc_we = 1'b0; gc_we = 1'b0; tg_we = 1'b0;
    lc_addr = CntW'({slot_r, cidx_r[MaxHistory-1:0]});
    gc_addr = cidx_r[MaxHistory-1:0];
    lc_wd = new_cnt; gc_wd = new_cnt;
    if (clr_busy_r) begin
      // Both counter RAMs take the reset state; the shared one is covered by the low part.
      lc_we = 1'b1; lc_addr = clr_r; lc_wd = CNT_INIT_RESET;
      gc_we = 1'b1; gc_addr = clr_r[MaxHistory-1:0]; gc_wd = CNT_INIT_RESET;
    end else begin
      unique case (state_r)
        ST_FILL: begin
          lc_we = 1'b1; lc_addr = CntW'({slot_r, fill_r[MaxHistory-1:0]}); lc_wd = init_r;
        end
        ST_WRITE: begin
          tg_we = 1'b1;
          if (gtab_r) gc_we = 1'b1; else lc_we = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; clr_busy_r <= 1'b1; clr_r <= '0;
      ev_r <= '0; ghist_val_r <= '0;
      br_r <= '0; fl_r <= '0; ovalid_r <= 1'b0; fill_r <= '0;
      for (int i = 0; i < MaxBtbEntries; i++) lhist_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_busy_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == CntW'(CntN - 1)) clr_busy_r <= 1'b0;
      end
      // The result register loads when free or when its transfer happens now.
      if (state_r == ST_OUT && (!ovalid_r || !out_stall)) ovalid_r <= 1'b1;
      else if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (taking) begin
          item_r <= in_data; slot_r <= slot_c; tag_r <= tag_c;
          hit_r <= hit_c;
          hist_r <= hist_c; cidx_r <= cidx_c; fill_r <= '0;
        end
        ST_READ: ;
        ST_EVAL: begin
          cnt_r <= cnt_now;
          pred_r <= hit_r && cnt_now[1];
          if (item_r.command) begin
            br_r <= br_r + 32'd1;
            if ((item_r.taken != (hit_r && cnt_now[1])) ||
                (item_r.taken && item_r.target_pc != item_r.predicted_dest))
              fl_r <= fl_r + 32'd1;
          end
        end
        ST_FILL: fill_r <= fill_r + 9'd1;
        ST_WRITE: begin
          ev_r[slot_r] <= 1'b1;
          etag_r[slot_r] <= tag_r;
          if (ghist_r) ghist_val_r <= {hist_r[6:0], item_r.taken};
          else if (miss_u) lhist_r[slot_r] <= {7'd0, item_r.taken};
          else lhist_r[slot_r] <= {hist_r[6:0], item_r.taken};
        end
        ST_OUT: if (!ovalid_r || !out_stall) begin
          out_r.pred_taken <= !item_r.command && pred_r;
          out_r.pred_dest  <= item_r.command ? 32'd0 :
                              (pred_r ? tg_rd : item_r.pc + 32'd4);
          out_r.branch_count <= br_r;
          out_r.flush_count  <= fl_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = out_r;
endmodule

@@ rtl/core/tlbp_checker.sv @@
// Port-level checker for the branch predictor, bound to the top level.
module tlbp_checker
  import tlbp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);
  // An accepted item blocks the next one in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("second item taken");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed under stall");

  // Flush count never runs ahead of branch count changes.
  a_flush_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall) |=> (!out_valid || out_stall ||
      out_data.flush_count == $past(out_data.flush_count) ||
      out_data.branch_count != $past(out_data.branch_count)))
    else $error("flush without branch");

  // A valid result carries no unknown bits.
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data))
    else $error("unknown result bits");
endmodule

bind two_level_branch_predictor_btb_unit tlbp_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data);
